/* sv/point_distance_tolerance_check_unit_assert.svh */
// assertion macros shared by the checker of the distance tolerance unit
// expects clk and rst to be visible where the macros are used
`ifndef POINT_DISTANCE_TOLERANCE_CHECK_UNIT_ASSERT_SVH
`define POINT_DISTANCE_TOLERANCE_CHECK_UNIT_ASSERT_SVH

// property that must hold in the same cycle as its trigger
`define PTDC_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// property that must hold in the cycle after its trigger
`define PTDC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

/* sv/ptdc_pkg.sv */
// shared types and codes of the point distance tolerance check unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ptdc_pkg;

  // mode codes on the input tuser; bit 0 selects the plane and wins
  localparam logic [1:0] MODE_POINT     = 2'd0;
  localparam logic [1:0] MODE_PLANE     = 2'd1;
  localparam logic [1:0] MODE_LINE      = 2'd2;
  localparam logic [1:0] MODE_PLANE_ALT = 2'd3;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_UPPER = 1'b0,
    REG_LOWER = 1'b1
  } reg_idx_t;

  // per-item control flags handed from the front end to the back end
  typedef struct packed {
    logic plane;
    logic line;
    logic degen;
  } ctl_t;

endpackage

`default_nettype wire

/* sv/ptdc_delay.sv */
// delay line with stall enable, used to keep side data aligned with the
// arithmetic units; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ptdc_delay #(
  parameter int DW    = 8,
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [DW-1:0] din,
  output logic [DW-1:0] dout
);

  logic [DW-1:0] taps [DEPTH];

  // shift one place per enabled cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < DEPTH; k++) taps[k] <= '0;
    end else if (en) begin
      taps[0] <= din;
      for (int k = 1; k < DEPTH; k++) taps[k] <= taps[k-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

`default_nettype wire

/* sv/ptdc_front.sv */
// front end: vector setup, dot products, squared length and the
// numerators of the projection quotients; uses ptdc_pkg and ptdc_delay
`timescale 1ns / 1ps
`default_nettype none

module ptdc_front #(
  parameter int CW = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [1:0]             mode,
  input  logic [2:0][CW-1:0]     pnt,
  input  logic [2:0][CW-1:0]     anc,
  input  logic [2:0][CW-1:0]     aux,
  output logic                   out_valid,
  output ptdc_pkg::ctl_t         ctl,
  output logic [2:0][3*CW+2:0]   num,
  output logic [2*CW+1:0]        den,
  output logic [2:0]             qneg,
  output logic [2:0][CW-1:0]     pnt_o,
  output logic [2:0][CW-1:0]     anc_o
);

  localparam int VW   = CW + 1;       // difference vectors
  localparam int PW   = 2 * CW + 2;   // products of two differences
  localparam int SW   = 2 * CW + 3;   // signed dot product
  localparam int MW   = 2 * CW + 2;   // dot product magnitude
  localparam int HW   = CW + 1;       // half of the magnitude
  localparam int LW   = HW + CW;      // partial product
  localparam int NUMW = 3 * CW + 3;   // numerator

  logic dec_plane, dec_line;

  logic                 a_valid, a_plane, a_line;
  logic [2:0][CW-1:0]   a_p, a_a;
  logic signed [VW-1:0] a_d [3];
  logic signed [VW-1:0] a_v [3];

  logic signed [PW-1:0] b_dv [3];
  logic signed [PW-1:0] b_vv [3];
  logic signed [VW-1:0] b_v  [3];
  logic signed [VW-1:0] vabs [3];

  logic signed [SW-1:0] c_s;
  logic [MW-1:0]        c_n2;
  logic [2:0]           c_vneg;
  logic [CW-1:0]        c_vmag [3];
  logic signed [SW-1:0] sabs;

  logic [MW-1:0]        d_smag;
  logic [2:0]           d_qneg;
  logic [CW-1:0]        d_vmag [3];
  logic [MW-1:0]        d_n2;

  logic [LW-1:0]        e_lo [3];
  logic [LW-1:0]        e_hi [3];
  logic [2:0]           e_qneg;
  logic [MW-1:0]        e_n2;

  logic [2:0][NUMW-1:0] f_num;
  logic [2:0]           f_qneg;
  logic [MW-1:0]        f_n2;
  logic                 f_plane, f_line;

  // mode decode
  always_comb begin
    dec_plane = 1'b0;
    dec_line  = 1'b0;
    case (mode)
      ptdc_pkg::MODE_PLANE, ptdc_pkg::MODE_PLANE_ALT: dec_plane = 1'b1;
      ptdc_pkg::MODE_LINE:                            dec_line  = 1'b1;
      default: ;
    endcase
  end

  // stage a: d = p - a, v = normal or line direction
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_plane <= dec_plane;
      a_line  <= dec_line;
      a_p     <= pnt;
      a_a     <= anc;
      for (int i = 0; i < 3; i++) begin
        a_d[i] <= $signed({pnt[i][CW-1], pnt[i]}) - $signed({anc[i][CW-1], anc[i]});
        if (dec_plane) begin
          a_v[i] <= $signed({aux[i][CW-1], aux[i]});
        end else begin
          a_v[i] <= $signed({aux[i][CW-1], aux[i]}) - $signed({anc[i][CW-1], anc[i]});
        end
      end
    end
  end

  // stage b: element products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        b_dv[i] <= a_d[i] * a_v[i];
        b_vv[i] <= a_v[i] * a_v[i];
        b_v[i]  <= a_v[i];
      end
    end
  end

  // stage c: dot product, squared length, direction magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vabs[i] = b_v[i][VW-1] ? -b_v[i] : b_v[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_s  <= SW'(b_dv[0]) + SW'(b_dv[1]) + SW'(b_dv[2]);
      c_n2 <= $unsigned(b_vv[0]) + $unsigned(b_vv[1]) + $unsigned(b_vv[2]);
      for (int i = 0; i < 3; i++) begin
        c_vneg[i] <= b_v[i][VW-1];
        c_vmag[i] <= vabs[i][CW-1:0];
      end
    end
  end

  // stage d: dot product magnitude and quotient signs
  assign sabs = c_s[SW-1] ? -c_s : c_s;

  always_ff @(posedge clk) begin
    if (en) begin
      d_smag <= sabs[MW-1:0];
      d_n2   <= c_n2;
      for (int i = 0; i < 3; i++) begin
        d_qneg[i] <= c_s[SW-1] ^ c_vneg[i];
        d_vmag[i] <= c_vmag[i];
      end
    end
  end

  // stage e: |s| * |v_i| split into two half-width products
  always_ff @(posedge clk) begin
    if (en) begin
      e_qneg <= d_qneg;
      e_n2   <= d_n2;
      for (int i = 0; i < 3; i++) begin
        e_lo[i] <= d_smag[HW-1:0] * d_vmag[i];
        e_hi[i] <= d_smag[MW-1:HW] * d_vmag[i];
      end
    end
  end

  // stage f: recombine the partial products
  always_ff @(posedge clk) begin
    if (en) begin
      f_qneg <= e_qneg;
      f_n2   <= e_n2;
      for (int i = 0; i < 3; i++) begin
        f_num[i] <= NUMW'(e_lo[i]) + (NUMW'(e_hi[i]) << HW);
      end
    end
  end

  // side data follows stage a to stage f
  ptdc_delay #(
    .DW    (3 + 6 * CW),
    .DEPTH (5)
  ) u_side (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  ({a_valid, a_plane, a_line, a_p, a_a}),
    .dout ({out_valid, f_plane, f_line, pnt_o, anc_o})
  );

  // a zero normal or zero-length line is degenerate
  always_comb begin
    ctl.plane = f_plane;
    ctl.line  = f_line;
    ctl.degen = (f_plane || f_line) && (f_n2 == '0);
  end

  assign num  = f_num;
  assign den  = f_n2;
  assign qneg = f_qneg;

endmodule

`default_nettype wire

/* sv/ptdc_div.sv */
// pipelined restoring divider, one quotient bit per stage
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ptdc_div #(
  parameter int NUMW = 99,
  parameter int DENW = 66,
  parameter int QW   = 33
) (
  input  logic            clk,
  input  logic            en,
  input  logic [NUMW-1:0] num,
  input  logic [DENW-1:0] den,
  output logic [QW-1:0]   quo
);

  logic [NUMW-1:0] rem_i [QW];
  logic [DENW-1:0] den_i [QW];
  logic [QW-1:0]   quo_i [QW];
  logic [NUMW-1:0] rem_q [QW];
  logic [DENW-1:0] den_q [QW];
  logic [QW-1:0]   quo_q [QW];
  logic [NUMW-1:0] trial [QW];
  logic            fit   [QW];

  // stage inputs and trial subtrahends, highest quotient bit first
  always_comb begin
    rem_i[0] = num;
    den_i[0] = den;
    quo_i[0] = '0;
    for (int k = 1; k < QW; k++) begin
      rem_i[k] = rem_q[k-1];
      den_i[k] = den_q[k-1];
      quo_i[k] = quo_q[k-1];
    end
    for (int k = 0; k < QW; k++) begin
      trial[k] = {{(NUMW-DENW){1'b0}}, den_i[k]} << (QW - 1 - k);
      fit[k]   = rem_i[k] >= trial[k];
    end
  end

  // one compare and subtract per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        rem_q[k] <= fit[k] ? rem_i[k] - trial[k] : rem_i[k];
        den_q[k] <= den_i[k];
        quo_q[k] <= quo_i[k] | (QW'(fit[k]) << (QW - 1 - k));
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

`default_nettype wire

/* sv/ptdc_isqrt.sv */
// pipelined integer square root, one root bit per stage, floor result
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ptdc_isqrt #(
  parameter int RW = 34
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] rad,
  output logic [RW-1:0]   root
);

  localparam int XW = 2 * RW;

  logic [XW-1:0] rem_i [RW];
  logic [RW-1:0] y_i   [RW];
  logic [XW-1:0] rem_q [RW];
  logic [RW-1:0] y_q   [RW];
  logic [XW-1:0] trial [RW];
  logic          fit   [RW];

  // (y + 2^b)^2 - y^2 = y * 2^(b+1) + 2^(2b)
  always_comb begin
    rem_i[0] = rad;
    y_i[0]   = '0;
    for (int k = 1; k < RW; k++) begin
      rem_i[k] = rem_q[k-1];
      y_i[k]   = y_q[k-1];
    end
    for (int k = 0; k < RW; k++) begin
      trial[k] = ({{RW{1'b0}}, y_i[k]} << (RW - k)) | (XW'(1) << (2 * (RW - 1 - k)));
      fit[k]   = rem_i[k] >= trial[k];
    end
  end

  // remainder update and root bit per stage
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < RW; k++) begin
        rem_q[k] <= fit[k] ? rem_i[k] - trial[k] : rem_i[k];
        y_q[k]   <= y_i[k] | (RW'(fit[k]) << (RW - 1 - k));
      end
    end
  end

  assign root = y_q[RW-1];

endmodule

`default_nettype wire

/* sv/point_distance_tolerance_check_unit.sv */
// top level of the point distance tolerance check unit
// uses ptdc_pkg, ptdc_front, ptdc_div, ptdc_isqrt and ptdc_delay
`timescale 1ns / 1ps
`default_nettype none

// Measures the distance from a point to another point, to a plane through
// the anchor with the given normal, or to the infinite line from the anchor
// to the aux point, and flags whether it lies within the two tolerance
// registers. Coordinates are signed fixed point with any number of fraction
// bits; distance and tolerances use the same scale, unsigned. The unit is a
// fully pipelined datapath: while the output is not stalled, one item is
// accepted per clock and one result leaves per clock. The path runs through
// six front-end stages, COORD_WIDTH + 1 divider stages, five foot and
// squaring stages, COORD_WIDTH + 2 square root stages and the output
// register. The whole pipe advances when the output register is empty or
// its beat is taken, so s_tready follows m_tready in the same cycle.
// Tolerance writes are expected only while no item is in flight.

module point_distance_tolerance_check_unit #(
  parameter  int COORD_WIDTH = 32,
  localparam int SDW = ((9 * COORD_WIDTH + 7) / 8) * 8,
  localparam int MDW = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  // input stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // point_x, point_y, point_z, anchor_x, anchor_y, anchor_z, aux_x, aux_y, aux_z
  input  logic [SDW-1:0]         s_tdata,
  // mode
  input  logic [1:0]             s_tuser,
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // distance, foot_x, foot_y, foot_z
  output logic [MDW-1:0]         m_tdata,
  // in_range, degenerate, saturated
  output logic [2:0]             m_tuser,
  // tolerance registers
  input  logic                   cfg_we,
  input  logic [0:0]             cfg_addr,
  input  logic [COORD_WIDTH-1:0] cfg_data
);

  localparam int CW   = COORD_WIDTH;
  localparam int QW   = CW + 1;
  localparam int NUMW = 3 * CW + 3;
  localparam int DENW = 2 * CW + 2;
  localparam int QSW  = CW + 2;
  localparam int FW   = CW + 3;
  localparam int EW   = CW + 1;
  localparam int SQW  = 2 * EW;
  localparam int RW   = CW + 2;
  localparam int XW   = 2 * RW;

  logic en;

  logic [CW-1:0] upper_tol, lower_tol;

  logic                 f_valid;
  ptdc_pkg::ctl_t       f_ctl;
  logic [2:0][NUMW-1:0] f_num;
  logic [DENW-1:0]      f_den;
  logic [2:0]           f_qneg;
  logic [2:0][CW-1:0]   f_pnt, f_anc;

  logic [QW-1:0]        quo [3];
  logic                 dv;
  ptdc_pkg::ctl_t       dctl;
  logic [2:0]           dqneg;
  logic [2:0][CW-1:0]   dp, da;

  logic signed [QSW-1:0] q_ext [3];

  logic                  g_v;
  ptdc_pkg::ctl_t        g_ctl;
  logic [2:0][CW-1:0]    g_p, g_a;
  logic signed [QSW-1:0] g_q [3];

  logic                  h_v, h_degen;
  logic [2:0][CW-1:0]    h_p;
  logic signed [FW-1:0]  h_f [3];

  logic signed [FW-1:0]  e_c   [3];
  logic signed [FW-1:0]  e_abs [3];
  logic [2:0]            f_fit;
  logic [2:0][CW-1:0]    f_clip;

  logic                  i_v, i_degen, i_satf;
  logic [2:0][CW-1:0]    i_foot;
  logic [EW-1:0]         i_emag [3];

  logic                  j_v, j_degen, j_satf;
  logic [2:0][CW-1:0]    j_foot;
  logic [SQW-1:0]        j_sq [3];

  logic                  k_v, k_degen, k_satf;
  logic [2:0][CW-1:0]    k_foot;
  logic [XW-1:0]         k_sum;

  logic [RW-1:0]         root;
  logic                  r_v, r_degen, r_satf;
  logic [2:0][CW-1:0]    r_foot;

  logic [CW-1:0]         dist_clip;
  logic                  dist_sat, dist_ok;

  // pipe advances unless a finished beat is stuck at the output
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // tolerance registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_tol <= '1;
      lower_tol <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ptdc_pkg::REG_UPPER: upper_tol <= cfg_data;
        ptdc_pkg::REG_LOWER: lower_tol <= cfg_data;
        default: ;
      endcase
    end
  end

  // geometry front end
  ptdc_front #(
    .CW (CW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .mode      (s_tuser),
    .pnt       (s_tdata[3*CW-1:0]),
    .anc       (s_tdata[6*CW-1:3*CW]),
    .aux       (s_tdata[9*CW-1:6*CW]),
    .out_valid (f_valid),
    .ctl       (f_ctl),
    .num       (f_num),
    .den       (f_den),
    .qneg      (f_qneg),
    .pnt_o     (f_pnt),
    .anc_o     (f_anc)
  );

  // one divider lane per axis
  for (genvar i = 0; i < 3; i++) begin : g_lane
    ptdc_div #(
      .NUMW (NUMW),
      .DENW (DENW),
      .QW   (QW)
    ) u_div (
      .clk (clk),
      .en  (en),
      .num (f_num[i]),
      .den (f_den),
      .quo (quo[i])
    );
  end

  ptdc_delay #(
    .DW    (7 + 6 * CW),
    .DEPTH (QW)
  ) u_div_side (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  ({f_valid, f_ctl, f_qneg, f_pnt, f_anc}),
    .dout ({dv, dctl, dqneg, dp, da})
  );

  // stage g: signed quotients
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_ext[i] = $signed({1'b0, quo[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_v <= 1'b0;
    end else if (en) begin
      g_v <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_ctl <= dctl;
      g_p   <= dp;
      g_a   <= da;
      for (int i = 0; i < 3; i++) begin
        g_q[i] <= dqneg[i] ? -q_ext[i] : q_ext[i];
      end
    end
  end

  // stage h: unclipped foot point
  always_ff @(posedge clk) begin
    if (rst) begin
      h_v <= 1'b0;
    end else if (en) begin
      h_v <= g_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_degen <= g_ctl.degen;
      h_p     <= g_p;
      for (int i = 0; i < 3; i++) begin
        if (g_ctl.degen) begin
          h_f[i] <= FW'($signed(g_p[i]));
        end else if (g_ctl.plane) begin
          h_f[i] <= FW'($signed(g_p[i])) - FW'(g_q[i]);
        end else if (g_ctl.line) begin
          h_f[i] <= FW'($signed(g_a[i])) + FW'(g_q[i]);
        end else begin
          h_f[i] <= FW'($signed(g_a[i]));
        end
      end
    end
  end

  // stage i: error vector magnitude and foot clipping
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e_c[i]   = FW'($signed(h_p[i])) - h_f[i];
      e_abs[i] = e_c[i][FW-1] ? -e_c[i] : e_c[i];
      f_fit[i] = (h_f[i][FW-1:CW-1] == '0) || (h_f[i][FW-1:CW-1] == '1);
      if (f_fit[i]) begin
        f_clip[i] = h_f[i][CW-1:0];
      end else if (h_f[i][FW-1]) begin
        f_clip[i] = {1'b1, {(CW-1){1'b0}}};
      end else begin
        f_clip[i] = {1'b0, {(CW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_v <= 1'b0;
    end else if (en) begin
      i_v <= h_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      i_degen <= h_degen;
      i_satf  <= !(&f_fit);
      i_foot  <= f_clip;
      for (int i = 0; i < 3; i++) begin
        i_emag[i] <= e_abs[i][EW-1:0];
      end
    end
  end

  // stage j: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      j_v <= 1'b0;
    end else if (en) begin
      j_v <= i_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      j_degen <= i_degen;
      j_satf  <= i_satf;
      j_foot  <= i_foot;
      for (int i = 0; i < 3; i++) begin
        j_sq[i] <= i_emag[i] * i_emag[i];
      end
    end
  end

  // stage k: sum of squares
  always_ff @(posedge clk) begin
    if (rst) begin
      k_v <= 1'b0;
    end else if (en) begin
      k_v <= j_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_degen <= j_degen;
      k_satf  <= j_satf;
      k_foot  <= j_foot;
      k_sum   <= XW'(j_sq[0]) + XW'(j_sq[1]) + XW'(j_sq[2]);
    end
  end

  // square root and its side data
  ptdc_isqrt #(
    .RW (RW)
  ) u_isqrt (
    .clk  (clk),
    .en   (en),
    .rad  (k_sum),
    .root (root)
  );

  ptdc_delay #(
    .DW    (3 + 3 * CW),
    .DEPTH (RW)
  ) u_sqrt_side (
    .clk  (clk),
    .rst  (rst),
    .en   (en),
    .din  ({k_v, k_degen, k_satf, k_foot}),
    .dout ({r_v, r_degen, r_satf, r_foot})
  );

  // distance clipping and tolerance window
  always_comb begin
    dist_sat  = root[RW-1:CW] != '0;
    dist_clip = dist_sat ? '1 : root[CW-1:0];
    dist_ok   = (dist_clip >= lower_tol) && (dist_clip <= upper_tol);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= r_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= MDW'({r_foot, dist_clip});
      m_tuser <= {r_satf || dist_sat, r_degen, dist_ok};
    end
  end

endmodule

`default_nettype wire

/* sv/ptdc_checker.sv */
// port-level checks of the point distance tolerance check unit, bound to
// the top level; uses ptdc_pkg and the assertion macro header
`timescale 1ns / 1ps
`default_nettype none
`include "point_distance_tolerance_check_unit_assert.svh"

module ptdc_checker #(
  parameter  int COORD_WIDTH = 32,
  localparam int MDW = ((4 * COORD_WIDTH + 7) / 8) * 8
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [MDW-1:0]         m_tdata,
  input logic [2:0]             m_tuser,
  input logic                   cfg_we,
  input logic [0:0]             cfg_addr,
  input logic [COORD_WIDTH-1:0] cfg_data
);

  logic [COORD_WIDTH-1:0] upper_q, lower_q;
  logic [COORD_WIDTH-1:0] dist_val;
  logic                   win_ok;

  assign dist_val = m_tdata[COORD_WIDTH-1:0];
  assign win_ok   = (dist_val >= lower_q) && (dist_val <= upper_q);

  // shadow copies of the tolerance registers
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_q <= '1;
      lower_q <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        ptdc_pkg::REG_UPPER: upper_q <= cfg_data;
        ptdc_pkg::REG_LOWER: lower_q <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stalled output beat holds
  `PTDC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}), "stalled beat changed")

  // a stuck output beat stops the input side
  `PTDC_ASSERT_NOW(a_in_stall, m_tvalid && !m_tready, !s_tready, "input ready while output stalled")

  // degenerate references give zero distance
  `PTDC_ASSERT_NOW(a_degen_zero, m_tvalid && m_tuser[1], dist_val == '0, "degenerate nonzero distance")

  // range flag agrees with the tolerance window
  `PTDC_ASSERT_NOW(a_range_flag, m_tvalid, m_tuser[0] == win_ok, "range flag disagrees with tolerances")

endmodule

bind point_distance_tolerance_check_unit ptdc_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_ptdc_checker (.*);

`default_nettype wire

/* tb/sv/tb_point_distance_tolerance_check_unit.sv */
// testbench for the point distance tolerance check unit: directed, sweep and random beats
// checked against an in-bench distance predictor; depends on ptdc_pkg and the unit rtl
`timescale 1ns / 1ps

module tb_point_distance_tolerance_check_unit;

  localparam int CW = 32;
  localparam logic signed [31:0] CMAX = 32'sh7fffffff;
  localparam logic signed [31:0] CMIN = 32'sh80000000;
  localparam int DRAIN_CYCLES = 2 * CW + 40;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic [31:0] distance;
    coord_t      foot_x;
    coord_t      foot_y;
    coord_t      foot_z;
    logic        in_range;
    logic        degenerate;
    logic        saturated;
  } dist_result_t;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [287:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [127:0] m_tdata;
  logic [2:0] m_tuser;
  logic cfg_we = 0;
  logic [0:0] cfg_addr = '0;
  logic [31:0] cfg_data = '0;

  // tolerance registers as the predictor sees them
  logic [31:0] tol_upper = 32'hffffffff;
  logic [31:0] tol_lower = 32'h0;

  dist_result_t expected_results[$];
  int errors = 0;
  bit tx_idle_en = 0;
  bit rx_idle_en = 0;
  int rx_hold_cycles = 0;

  point_distance_tolerance_check_unit #(.COORD_WIDTH(CW)) uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // distance, foot point and flags for one beat
  function automatic dist_result_t predict_distance(logic [1:0] mode, coord_t p[3],
                                                    coord_t a[3], coord_t x[3]);
    dist_result_t r;
    logic signed [159:0] pv[3], av[3], xv[3], bv[3], fv[3];
    logic signed [159:0] num, den, diff;
    logic [159:0] sumsq;
    logic [127:0] root, cand;
    r = '0;
    num = 0;
    den = 0;
    for (int i = 0; i < 3; i++) begin
      pv[i] = p[i];
      av[i] = a[i];
      xv[i] = x[i];
      fv[i] = av[i];
    end
    if (mode[0]) begin
      for (int i = 0; i < 3; i++) begin
        den += xv[i] * xv[i];
        num += (pv[i] - av[i]) * xv[i];
      end
      if (den == 0) begin
        r.degenerate = 1;
        for (int i = 0; i < 3; i++) fv[i] = pv[i];
      end else begin
        for (int i = 0; i < 3; i++) fv[i] = pv[i] - (num * xv[i]) / den;
      end
    end else if (mode[1]) begin
      for (int i = 0; i < 3; i++) begin
        bv[i] = xv[i] - av[i];
        den += bv[i] * bv[i];
        num += bv[i] * (pv[i] - av[i]);
      end
      if (den == 0) begin
        r.degenerate = 1;
        for (int i = 0; i < 3; i++) fv[i] = pv[i];
      end else begin
        for (int i = 0; i < 3; i++) fv[i] = av[i] + (num * bv[i]) / den;
      end
    end
    // integer square root of the squared length, from the unclipped foot
    sumsq = 0;
    for (int i = 0; i < 3; i++) begin
      diff = pv[i] - fv[i];
      sumsq += diff * diff;
    end
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'd1 << b);
      if (cand * cand <= sumsq) root = cand;
    end
    if (root > 128'hffffffff) begin
      r.distance = 32'hffffffff;
      r.saturated = 1;
    end else begin
      r.distance = root[31:0];
    end
    // clip the foot point to the coordinate range
    for (int i = 0; i < 3; i++) begin
      if (fv[i] > 160'(CMAX)) begin
        fv[i] = CMAX;
        r.saturated = 1;
      end
      if (fv[i] < 160'(CMIN)) begin
        fv[i] = CMIN;
        r.saturated = 1;
      end
    end
    r.foot_x = fv[0][31:0];
    r.foot_y = fv[1][31:0];
    r.foot_z = fv[2][31:0];
    r.in_range = (r.distance >= tol_lower) && (r.distance <= tol_upper);
    return r;
  endfunction

  // predict on every accepted input beat
  always @(posedge clk) begin
    coord_t p[3], a[3], x[3];
    if (!rst && s_tvalid && s_tready) begin
      for (int i = 0; i < 3; i++) begin
        p[i] = s_tdata[32*i +: 32];
        a[i] = s_tdata[96 + 32*i +: 32];
        x[i] = s_tdata[192 + 32*i +: 32];
      end
      expected_results.push_back(predict_distance(s_tuser, p, a, x));
    end
  end

  // compare every accepted result beat with the oldest prediction
  always @(posedge clk) begin
    dist_result_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.distance = m_tdata[31:0];
      got.foot_x = m_tdata[63:32];
      got.foot_y = m_tdata[95:64];
      got.foot_z = m_tdata[127:96];
      got.in_range = m_tuser[0];
      got.degenerate = m_tuser[1];
      got.saturated = m_tuser[2];
      if (expected_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // receiver: long hold-offs on request, random stalls while idling is enabled, otherwise always ready
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (rx_hold_cycles > 0) begin
      m_tready <= 0;
      rx_hold_cycles--;
    end else if (rx_idle_en) begin
      m_tready <= ($urandom_range(99) >= 32);
    end else begin
      m_tready <= 1;
    end
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_point(logic [1:0] mode, coord_t p[3], coord_t a[3], coord_t x[3]);
    while (tx_idle_en && $urandom_range(99) < 32) begin
      s_tvalid <= 0;
      @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= mode;
    s_tdata <= {x[2], x[1], x[0], a[2], a[1], a[0], p[2], p[1], p[0]};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic drain_results();
    s_tvalid <= 0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_tolerance(ptdc_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == ptdc_pkg::REG_UPPER) tol_upper = value;
    else tol_lower = value;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(4))
      0: return $urandom_range(8191) - 4096;
      1: return $signed($urandom) >>> $urandom_range(20, 8);
      2: case ($urandom_range(3))
           0: return CMAX;
           1: return CMIN;
           2: return 0;
           default: return -1;
         endcase
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random_point();
    coord_t p[3], a[3], x[3];
    logic [1:0] mode;
    mode = $urandom_range(3);
    for (int i = 0; i < 3; i++) begin
      p[i] = rand_coord();
      a[i] = rand_coord();
      x[i] = rand_coord();
    end
    // sometimes a zero normal or a zero-length line
    if ($urandom_range(19) == 0) begin
      for (int i = 0; i < 3; i++) x[i] = (mode[0]) ? 0 : a[i];
    end
    send_point(mode, p, a, x);
  endtask

  task automatic test_directed();
    coord_t p[3], a[3], x[3];
    // point mode, aux ignored, extremes and saturated distance
    p = '{CMAX, CMAX, CMAX}; a = '{CMIN, CMIN, CMIN}; x = '{5, -7, 9};
    send_point(ptdc_pkg::MODE_POINT, p, a, x);
    p = '{0, 0, 0}; a = '{0, 0, 0}; x = '{CMIN, CMAX, -1};
    send_point(ptdc_pkg::MODE_POINT, p, a, x);
    p = '{4096, 8192, -4096}; a = '{0, 0, 0}; x = '{0, 0, 0};
    send_point(ptdc_pkg::MODE_POINT, p, a, x);
    // plane modes, including mode three
    p = '{1000, 2000, 3000}; a = '{0, 0, 0}; x = '{0, 0, 4096};
    send_point(ptdc_pkg::MODE_PLANE, p, a, x);
    send_point(ptdc_pkg::MODE_PLANE_ALT, p, a, x);
    p = '{CMAX, CMAX, 0}; a = '{CMIN, CMIN, 0}; x = '{1, 1, 0};
    send_point(ptdc_pkg::MODE_PLANE, p, a, x);
    p = '{CMIN, CMAX, CMIN}; a = '{CMAX, CMIN, CMAX}; x = '{CMIN, CMIN, CMAX};
    send_point(ptdc_pkg::MODE_PLANE_ALT, p, a, x);
    // zero normal
    p = '{12, -34, 56}; a = '{1, 2, 3}; x = '{0, 0, 0};
    send_point(ptdc_pkg::MODE_PLANE, p, a, x);
    // line modes
    p = '{500, 500, 0}; a = '{0, 0, 0}; x = '{1000, 0, 0};
    send_point(ptdc_pkg::MODE_LINE, p, a, x);
    p = '{CMIN, CMAX, 0}; a = '{CMAX, 0, 0}; x = '{CMAX - 1, 1, 0};
    send_point(ptdc_pkg::MODE_LINE, p, a, x);
    p = '{CMAX, CMIN, CMAX}; a = '{CMIN, CMAX, CMIN}; x = '{CMAX, CMIN, CMAX};
    send_point(ptdc_pkg::MODE_LINE, p, a, x);
    // zero-length line
    p = '{-9, 9, 100}; a = '{77, -77, 5}; x = '{77, -77, 5};
    send_point(ptdc_pkg::MODE_LINE, p, a, x);
    p = '{CMAX, CMIN, -1}; a = '{CMIN, CMIN, CMIN}; x = '{CMIN, CMIN, CMIN};
    send_point(ptdc_pkg::MODE_LINE, p, a, x);
    drain_results();
  endtask

  task automatic test_tolerance_sweep();
    logic [31:0] uppers[6] = '{32'hffffffff, 32'h0, 32'h00010000, 32'h00000800,
                               32'h7fffffff, 32'h00100000};
    logic [31:0] lowers[6] = '{32'h0, 32'h0, 32'h00001000, 32'h00010000,
                               32'hffffffff, 32'h00000400};
    // includes crossed tolerances
    for (int s = 0; s < 6; s++) begin
      write_tolerance(ptdc_pkg::REG_UPPER, uppers[s]);
      write_tolerance(ptdc_pkg::REG_LOWER, lowers[s]);
      repeat (25) send_random_point();
      drain_results();
    end
    write_tolerance(ptdc_pkg::REG_UPPER, $urandom);
    write_tolerance(ptdc_pkg::REG_LOWER, $urandom_range(32'h00020000));
  endtask

  task automatic test_random_stream();
    // long stretch without idling, then random idling on both sides
    tx_idle_en = 0;
    rx_idle_en = 0;
    repeat (100) send_random_point();
    tx_idle_en = 1;
    rx_idle_en = 1;
    repeat (300) send_random_point();
    drain_results();
  endtask

  task automatic test_backpressure();
    // receiver stalls long enough for the pipe to fill and stall input
    rx_hold_cycles = 300;
    tx_idle_en = 0;
    repeat (100) send_random_point();
    tx_idle_en = 1;
    // sender pause until every result is back
    drain_results();
    repeat (30) send_random_point();
    drain_results();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_directed();
    rx_idle_en = 1;
    tx_idle_en = 1;
    test_tolerance_sweep();
    test_random_stream();
    test_backpressure();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
